// ===== sv/cmvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvp_pkg
// Shared widths, register indexes and reset values of the comb mask core.
// ----------------------------------------------------------------------------
package cmvp_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned FwW     = 13;
  localparam int unsigned FhW     = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THR_LOW  = 2'd0,
    REG_THR_HIGH = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } cmvp_reg_e;

  localparam logic [PixW-1:0] ThrLowRst  = 8'd30;
  localparam logic [PixW-1:0] ThrHighRst = 8'd30;
  localparam logic [FwW-1:0]  WidthRst   = 13'd1920;
  localparam logic [FhW-1:0]  HeightRst  = 16'd1080;
  localparam logic [FhW-1:0]  MinHeight  = 16'd3;
  localparam logic [PixW-1:0] MaskFull   = 8'd255;

  // one result as it sits in the output register
  typedef struct packed {
    logic [PixW-1:0] mask;
    logic            eof;
    logic            run_last;
  } cmvp_res_t;

endpackage

// ===== sv/comb_mask_vertical_product_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_mask_vertical_product_core
// Vertical product comb mask over one plane, rows kept in a line memory.
// ----------------------------------------------------------------------------
// a pixel is registered in stage a and its result in the output register; the
//   result for row y-1 is produced by the pixel of row y
// throughput: one pixel per cycle while the output is not stalled, set by the
//   single read-modify-write of the line memory; on the last row two results
//   per pixel, the next waiting in stage a for the second; reset: counters and
//   handshake state clear, thresholds 30, geometry 1920x1080; line memory not cleared
module comb_mask_vertical_product_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [cmvp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cmvp_pkg::CfgW-1:0]     cfg_data_i,
  // pixel stream in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] pixel_value
  // mask stream out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,   // [7:0] mask_value
  output logic                          m_axis_tlast_o,   // end_of_frame
  output logic                          m_axis_tuser_o    // [0] run_last
);

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = (XW + 1 > cmvp_pkg::FwW) ? XW + 1 : cmvp_pkg::FwW;
  localparam int unsigned PW = cmvp_pkg::PixW;
  localparam int unsigned LW = 2 * PW;
  localparam int unsigned DW = PW + 1;
  localparam int unsigned MW = 2 * DW;

  // configuration registers
  logic [PW-1:0]                thr_lo_q, thr_hi_q;
  logic [cmvp_pkg::FwW-1:0]     fw_q;
  logic [cmvp_pkg::FhW-1:0]     fh_q;
  logic                         geo_wr;

  assign geo_wr = cfg_we_i && (cfg_idx_i == cmvp_pkg::REG_WIDTH ||
                               cfg_idx_i == cmvp_pkg::REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lo_q <= cmvp_pkg::ThrLowRst;
      thr_hi_q <= cmvp_pkg::ThrHighRst;
      fw_q     <= cmvp_pkg::WidthRst;
      fh_q     <= cmvp_pkg::HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmvp_pkg::REG_THR_LOW:  thr_lo_q <= cfg_data_i[PW-1:0];
        cmvp_pkg::REG_THR_HIGH: thr_hi_q <= cfg_data_i[PW-1:0];
        cmvp_pkg::REG_WIDTH:    fw_q     <= cfg_data_i[cmvp_pkg::FwW-1:0];
        cmvp_pkg::REG_HEIGHT:   fh_q     <= cfg_data_i[cmvp_pkg::FhW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0]            eff_w;
  logic [cmvp_pkg::FhW-1:0] eff_h;

  always_comb begin
    if (fw_q == '0) begin
      eff_w = CW'(1);
    end else if (CW'(fw_q) > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(fw_q);
    end
    eff_h = (fh_q < cmvp_pkg::MinHeight) ? cmvp_pkg::MinHeight : fh_q;
  end

  // raster position
  logic [XW-1:0]            x_q, x_d;
  logic [cmvp_pkg::FhW-1:0] y_q, y_d;
  logic                     x_last, y_last, in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign x_last = (CW'(x_q) + CW'(1)) >= eff_w;
  assign y_last = y_q >= (eff_h - cmvp_pkg::FhW'(1));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (in_acc) begin
      if (x_last) begin
        x_d = '0;
        y_d = y_last ? '0 : y_q + cmvp_pkg::FhW'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (geo_wr) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // stage a: line memory read in flight
  logic          a_vld_q;
  logic [PW-1:0] a_pix_q;
  logic [XW-1:0] a_x_q;
  logic          a_ge1_q, a_ge2_q, a_lrow_q, a_eof_q;
  logic          a_adv, out_free;

  assign a_adv           = a_vld_q && out_free;
  assign s_axis_tready_o = !a_vld_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q  <= s_axis_tdata_i;
      a_x_q    <= x_q;
      a_ge1_q  <= (y_q != '0);
      a_ge2_q  <= (y_q[cmvp_pkg::FhW-1:1] != '0);
      a_lrow_q <= y_last;
      a_eof_q  <= x_last;
    end
  end

  // line memory: upper byte the row above, lower byte the centre row
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_q, fwd_data_q, line, wr_data;
  logic          fwd_q;

  assign line    = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {line[PW-1:0], a_pix_q};

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      line_mem[a_x_q] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= line_mem[x_q];
    end
  end

  // write-back to the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= a_adv && (a_x_q == x_q);
    end else if (a_adv) begin
      fwd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wr_data;
    end
  end

  // kernel
  logic signed [DW-1:0] d_above, d_below;
  logic signed [MW-1:0] prod;
  logic [PW-1:0]        mask;

  always_comb begin
    d_above = $signed({1'b0, line[LW-1:PW]}) - $signed({1'b0, line[PW-1:0]});
    d_below = $signed({1'b0, a_pix_q}) - $signed({1'b0, line[PW-1:0]});
    prod    = MW'(d_above) * MW'(d_below);
    if (!a_ge2_q) begin
      mask = '0;
    end else if (prod < $signed({{(MW-PW){1'b0}}, thr_lo_q})) begin
      mask = '0;
    end else if (prod > $signed({{(MW-PW){1'b0}}, thr_hi_q})) begin
      mask = cmvp_pkg::MaskFull;
    end else begin
      mask = prod[2*PW-1:PW];
    end
  end

  // output register with a pending border zero on the last row
  logic                out_vld_q, out_vld_d;
  cmvp_pkg::cmvp_res_t out_q, out_d;
  logic                sec_q, sec_d, sec_eof_q, sec_eof_d;
  logic                out_hs;

  assign out_hs   = out_vld_q && m_axis_tready_i;
  assign out_free = !out_vld_q || (m_axis_tready_i && !sec_q);

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    sec_d     = sec_q;
    sec_eof_d = sec_eof_q;
    if (a_adv && a_ge1_q) begin
      out_vld_d      = 1'b1;
      out_d.mask     = mask;
      out_d.eof      = 1'b0;
      out_d.run_last = !a_lrow_q;
      sec_d          = a_lrow_q;
      sec_eof_d      = a_eof_q;
    end else if (out_hs) begin
      if (sec_q) begin
        out_d.mask     = '0;
        out_d.eof      = sec_eof_q;
        out_d.run_last = 1'b1;
        sec_d          = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_q     <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      sec_q     <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    sec_eof_q <= sec_eof_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.mask;
  assign m_axis_tlast_o  = out_q.eof;
  assign m_axis_tuser_o  = out_q.run_last;

  // checks
  a_sec_needs_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> out_vld_q)
    else $error("border result pending without a valid output");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> a_vld_q)
    else $error("forwarded line data without an item in flight");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(geo_wr) == 1'b0 |-> CW'(x_q) < eff_w)
    else $error("column counter beyond the row width");

  a_adv_drains_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && sec_q && !m_axis_tready_i) |=> out_vld_q && sec_q)
    else $error("pending border result lost under back-pressure");

endmodule
